// ===== hw/rtl/kpeq_pkg.sv =====
// Shared types and constants for the key press event qualifier.
package kpeq_pkg;

   // Configuration registers are 32 bits wide.
   localparam int CFG_W           = 32;
   localparam int CSR_INDEX_W     = 8;
   localparam int COUNT_WIDTH_DEF = 32;
   localparam int REQ_DATA_W      = 8;
   localparam int RSP_DATA_W      = 8;

   // Register indexes on the configuration port
   localparam logic [CSR_INDEX_W-1:0] REG_RELEASE_MODE = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] REG_MIN_PRESS    = CSR_INDEX_W'(1);
   localparam logic [CSR_INDEX_W-1:0] REG_MAX_PRESS    = CSR_INDEX_W'(2);
   localparam logic [CSR_INDEX_W-1:0] REG_COOLDOWN     = CSR_INDEX_W'(3);

   // Word kinds on the request channel (carried in tuser)
   localparam logic OP_SAMPLE = 1'b0;
   localparam logic OP_TAKE   = 1'b1;

   // Effective settings after the inverted window override
   typedef struct packed {
      logic             rel;
      logic             fault;
      logic [CFG_W-1:0] min_press;
      logic [CFG_W-1:0] max_press;
      logic [CFG_W-1:0] cooldown;
   } kpeq_cfg_type;

   // Core status seen by the top level checks
   typedef struct packed {
      logic pending;
      logic cooldown_busy;
   } kpeq_status_type;

endpackage

// ===== hw/rtl/kpeq_csr.sv =====
// Configuration registers and the inverted window override.
module kpeq_csr
   import kpeq_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]       csr_wdata,
   output kpeq_cfg_type           cfg
);

   logic             release_mode_ff;
   logic [CFG_W-1:0] min_press_ff;
   logic [CFG_W-1:0] max_press_ff;
   logic [CFG_W-1:0] cooldown_ff;
   logic             fault;

   always_ff @(posedge clock) begin
      if (reset) begin
         release_mode_ff <= 1'b0;
         min_press_ff    <= '0;
         max_press_ff    <= '0;
         cooldown_ff     <= '0;
      end else if (csr_we) begin
         case (csr_index)
            REG_RELEASE_MODE: release_mode_ff <= csr_wdata[0];
            REG_MIN_PRESS:    min_press_ff    <= csr_wdata;
            REG_MAX_PRESS:    max_press_ff    <= csr_wdata;
            REG_COOLDOWN:     cooldown_ff     <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // Inverted window in release mode: fall back to press mode, zero minimum, no cooldown
   assign fault         = release_mode_ff && (max_press_ff < min_press_ff);
   assign cfg.fault     = fault;
   assign cfg.rel       = release_mode_ff && !fault;
   assign cfg.min_press = fault ? '0 : min_press_ff;
   assign cfg.max_press = max_press_ff;
   assign cfg.cooldown  = fault ? '0 : cooldown_ff;

endmodule

// ===== hw/rtl/kpeq_core.sv =====
// Press counter, cooldown counter and pending event flag.
module kpeq_core
   import kpeq_pkg::*;
#(
   parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            step_en,
   input  logic            step_op,
   input  logic            step_key,
   input  kpeq_cfg_type    cfg,
   output logic            event_out,
   output kpeq_status_type status
);

   localparam int CMP_W = (COUNT_WIDTH > CFG_W) ? COUNT_WIDTH : CFG_W;

   logic [COUNT_WIDTH-1:0] press_count_ff, press_count_in;
   logic [CFG_W-1:0]       cooldown_left_ff, cooldown_left_in;
   logic                   event_pending_ff, event_pending_in;

   logic [COUNT_WIDTH-1:0] count_inc;
   logic [CMP_W-1:0]       count_ext;
   logic [CMP_W-1:0]       count_inc_ext;
   logic [CMP_W-1:0]       min_ext;
   logic [CMP_W-1:0]       max_ext;

   // Saturate at all ones
   assign count_inc     = (&press_count_ff) ? press_count_ff
                                            : press_count_ff + COUNT_WIDTH'(1);
   assign count_ext     = CMP_W'(press_count_ff);
   assign count_inc_ext = CMP_W'(count_inc);
   assign min_ext       = CMP_W'(cfg.min_press);
   assign max_ext       = CMP_W'(cfg.max_press);

   always_comb begin
      press_count_in   = press_count_ff;
      cooldown_left_in = cooldown_left_ff;
      event_pending_in = event_pending_ff;
      event_out        = 1'b0;
      if (step_en) begin
         if (step_op == OP_TAKE) begin
            event_out        = event_pending_ff;
            event_pending_in = 1'b0;
         end else if (cooldown_left_ff != '0) begin
            // Cooldown runs down on released ticks only
            if (!step_key) begin
               cooldown_left_in = cooldown_left_ff - CFG_W'(1);
               press_count_in   = '0;
            end
         end else if (step_key) begin
            press_count_in = count_inc;
            if (!cfg.rel && (count_inc_ext >= min_ext)) begin
               event_pending_in = 1'b1;
               cooldown_left_in = cfg.cooldown;
               press_count_in   = '0;
            end
         end else begin
            if (cfg.rel && (count_ext >= min_ext) && (count_ext <= max_ext)) begin
               event_pending_in = 1'b1;
               cooldown_left_in = cfg.cooldown;
            end
            press_count_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         press_count_ff   <= '0;
         cooldown_left_ff <= '0;
         event_pending_ff <= 1'b0;
      end else begin
         press_count_ff   <= press_count_in;
         cooldown_left_ff <= cooldown_left_in;
         event_pending_ff <= event_pending_in;
      end
   end

   assign status.pending       = event_pending_ff;
   assign status.cooldown_busy = (cooldown_left_ff != '0);

endmodule

// ===== hw/rtl/key_press_event_qualifier.sv =====
// Top level of the key press event qualifier: request register, core, response register.
// A word is held in the request register, then stepped through the core into the response register.
// One word per cycle unless responses stall; the press/cooldown update is one pass in kpeq_core.
// Response stalls propagate back through the request register; req_tready drops only when
// both the request register and the response register are full and rsp_tready is low.
// Reset (synchronous, active high) clears all counters, the pending event, the
// configuration registers and both valid flags.
module key_press_event_qualifier
   import kpeq_pkg::*;
#(
   parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   // request channel
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_DATA_W-1:0]  req_tdata,   // [0] key_pressed, [7:1] zero
   input  logic                   req_tuser,   // [0] op (0 sample, 1 take)
   // response channel
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_DATA_W-1:0]  rsp_tdata,   // [0] event_out, [1] config_fault, [7:2] zero
   // configuration write port
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]       csr_wdata
);

   kpeq_cfg_type    cfg;
   kpeq_status_type status;

   logic req_fire;
   logic out_free;
   logic adv;
   logic core_event;

   // Request register
   logic s1_valid_ff, s1_valid_in;
   logic s1_op_ff;
   logic s1_key_ff;

   // Response register
   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_event_ff;
   logic rsp_fault_ff;

   // Response slot is free when empty or being drained this cycle
   assign out_free   = !rsp_valid_ff || rsp_tready;
   // Advance the request word into the core and response register
   assign adv        = s1_valid_ff && out_free;
   assign req_tready = !s1_valid_ff || out_free;
   assign req_fire   = req_tvalid && req_tready;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_fire) begin
         s1_valid_in = 1'b1;
      end else if (adv) begin
         s1_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (adv) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers: hold until the next load
   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_op_ff  <= req_tuser;
         s1_key_ff <= req_tdata[0];
      end
      if (adv) begin
         rsp_event_ff <= core_event;
         rsp_fault_ff <= cfg.fault;
      end
   end

   kpeq_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   kpeq_core #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .step_en   (adv),
      .step_op   (s1_op_ff),
      .step_key  (s1_key_ff),
      .cfg       (cfg),
      .event_out (core_event),
      .status    (status)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W-2){1'b0}}, rsp_fault_ff, rsp_event_ff};

   // Checks

   a_reset_clears_rsp: assert property (@(posedge clock)
      reset |=> !rsp_valid_ff)
      else $error("response valid after reset");

   a_take_clears_pending: assert property (@(posedge clock) disable iff (reset)
      (adv && (s1_op_ff == OP_TAKE)) |=> !status.pending)
      else $error("pending event survived a take");

   a_cooldown_press_idle: assert property (@(posedge clock) disable iff (reset)
      (adv && (s1_op_ff == OP_SAMPLE) && s1_key_ff && status.cooldown_busy)
      |=> ($stable(status.pending) && status.cooldown_busy))
      else $error("pressed tick changed state during cooldown");

   a_request_held: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !adv) |=> s1_valid_ff)
      else $error("request word dropped while stalled");

endmodule

// ===== bench/key_press_event_qualifier_tb.sv =====
// Self-checking testbench for the key press event qualifier: stream driver, monitor, predictor.
`timescale 1ns / 100ps

module key_press_event_qualifier_tb;
   import kpeq_pkg::*;

   localparam int CNT_W        = COUNT_WIDTH_DEF;
   localparam int RANDOM_WORDS = 1600;
   localparam int LIMIT_CYCLES = 600000;
   localparam int REPORT_MAX   = 10;

   // One request word and one predicted response
   typedef struct packed {
      logic op;
      logic pressed;
   } key_word_type;

   typedef struct packed {
      logic event_flag;
      logic fault;
   } key_result_type;

   // Receiver stall patterns
   typedef enum logic [1:0] {
      READY_ALWAYS,
      READY_COIN,
      READY_SPARSE,
      READY_PERIODIC
   } ready_mode_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_DATA_W-1:0]  req_tdata = '0;
   logic                   req_tuser = OP_SAMPLE;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic                   csr_we = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CFG_W-1:0]       csr_wdata = '0;

   key_press_event_qualifier DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Words waiting for the driver, and responses predicted but not yet seen
   key_word_type   pending_words[$];
   key_result_type expected_results[$];

   // Shadow copy of the configuration registers
   logic             cfg_release = 1'b0;
   logic [CFG_W-1:0] cfg_min     = '0;
   logic [CFG_W-1:0] cfg_max     = '0;
   logic [CFG_W-1:0] cfg_cool    = '0;

   // Shadow copy of the qualifier state
   logic [CNT_W-1:0] press_cnt  = '0;
   logic [CFG_W-1:0] cool_left  = '0;
   logic             ev_pending = 1'b0;

   int cycle_count     = 0;
   int error_count     = 0;
   int words_queued    = 0;
   int words_sent      = 0;
   int results_checked = 0;
   int events_seen     = 0;
   int fault_results   = 0;
   int phase_count     = 0;
   int burst_left      = 0;
   int gap_left        = 0;
   int ready_left      = 0;
   ready_mode_type ready_mode = READY_ALWAYS;

   // Advance the qualifier state by one accepted word and return its response.
   function automatic key_result_type qualify_word(logic op, logic pressed);
      key_result_type   res;
      logic             fault;
      logic             rel;
      logic [CFG_W-1:0] eff_min;
      logic [CFG_W-1:0] eff_cool;
      fault    = cfg_release && (cfg_max < cfg_min);
      rel      = cfg_release && !fault;
      eff_min  = fault ? '0 : cfg_min;
      eff_cool = fault ? '0 : cfg_cool;
      res.event_flag = 1'b0;
      res.fault      = fault;
      if (op == OP_TAKE) begin
         res.event_flag = ev_pending;
         ev_pending     = 1'b0;
      end else if (cool_left != '0) begin
         // cooldown runs only on released ticks; pressed ticks are ignored
         if (!pressed) begin
            cool_left = cool_left - 1'b1;
            press_cnt = '0;
         end
      end else if (pressed) begin
         if (press_cnt != '1)
            press_cnt = press_cnt + 1'b1;
         if (!rel && press_cnt >= eff_min) begin
            ev_pending = 1'b1;
            cool_left  = eff_cool;
            press_cnt  = '0;
         end
      end else begin
         // release qualifies only inside the window
         if (rel && press_cnt >= eff_min && press_cnt <= cfg_max) begin
            ev_pending = 1'b1;
            cool_left  = eff_cool;
         end
         press_cnt = '0;
      end
      return res;
   endfunction

   task automatic report_failure(string what);
      error_count++;
      if (error_count <= REPORT_MAX)
         $display("[%0d] %s", cycle_count, what);
   endtask

   // Cycle counter and watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("timeout after %0d cycles, %0d responses outstanding", cycle_count,
                  expected_results.size());
         $display("FAILED: results differ");
         $finish;
      end
   end

   // Driver: predict on every accepted word, then send the next word in bursts with gaps.
   always @(posedge clock) begin : driver
      key_word_type nxt;
      logic         nxt_valid;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            expected_results.push_back(qualify_word(req_tuser, req_tdata[0]));
            words_sent++;
         end
         if (!req_tvalid || req_tready) begin
            nxt_valid = 1'b0;
            if (burst_left == 0) begin
               // a quarter of the bursts are preceded by a gap
               gap_left   = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 8) : 0;
               burst_left = $urandom_range(1, 32);
            end
            if (gap_left != 0) begin
               gap_left--;
            end else if (pending_words.size() != 0) begin
               nxt        = pending_words.pop_front();
               nxt_valid  = 1'b1;
               burst_left--;
               req_tuser <= nxt.op;
               req_tdata <= REQ_DATA_W'(nxt.pressed);
            end
            req_tvalid <= nxt_valid;
         end
      end
   end

   // Receiver stall pattern: switch to a randomly chosen mode whenever the mode counter runs out.
   always @(posedge clock) begin
      if (ready_left == 0) begin
         ready_mode <= ready_mode_type'($urandom_range(0, 3));
         ready_left <= $urandom_range(16, 96);
      end else begin
         ready_left <= ready_left - 1;
      end
      case (ready_mode)
         READY_ALWAYS:   rsp_tready <= 1'b1;
         READY_COIN:     rsp_tready <= 1'($urandom_range(0, 1));
         READY_SPARSE:   rsp_tready <= ($urandom_range(0, 3) == 0);
         READY_PERIODIC: rsp_tready <= cycle_count[2];
         default:        rsp_tready <= 1'b1;
      endcase
   end

   // Monitor: compare each accepted response word with the oldest prediction.
   always @(posedge clock) begin : monitor
      key_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_results.size() == 0) begin
            report_failure($sformatf("unexpected response word %h", rsp_tdata));
         end else begin
            want = expected_results.pop_front();
            if (rsp_tdata[0] !== want.event_flag || rsp_tdata[1] !== want.fault)
               report_failure($sformatf(
                  "response %0d: expected event %b fault %b, got event %b fault %b",
                  results_checked, want.event_flag, want.fault, rsp_tdata[0], rsp_tdata[1]));
         end
         results_checked++;
         if (rsp_tdata[0] === 1'b1)
            events_seen++;
         if (rsp_tdata[1] === 1'b1)
            fault_results++;
      end
   end

   task automatic add_word(logic op, logic pressed);
      key_word_type w;
      w.op      = op;
      w.pressed = pressed;
      pending_words.push_back(w);
      words_queued++;
   endtask

   task automatic add_run(logic pressed, int count);
      repeat (count) add_word(OP_SAMPLE, pressed);
   endtask

   // Write one register and track it in the shadow copy; an unknown index is dropped.
   task automatic write_reg(logic [CSR_INDEX_W-1:0] idx, logic [CFG_W-1:0] value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      case (idx)
         REG_RELEASE_MODE: cfg_release = value[0];
         REG_MIN_PRESS:    cfg_min     = value;
         REG_MAX_PRESS:    cfg_max     = value;
         REG_COOLDOWN:     cfg_cool    = value;
         default: ;
      endcase
   endtask

   task automatic end_writes();
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic set_config(logic rel, logic [CFG_W-1:0] mn, logic [CFG_W-1:0] mx,
                             logic [CFG_W-1:0] cool);
      // upper bits of the mode write are noise the block must drop
      write_reg(REG_RELEASE_MODE, {(CFG_W-1)'($urandom()), rel});
      write_reg(REG_MIN_PRESS, mn);
      write_reg(REG_MAX_PRESS, mx);
      write_reg(REG_COOLDOWN, cool);
      end_writes();
   endtask

   // Hold until every queued word is sent and answered, then let the pipeline drain.
   task automatic settle(int drain_cycles);
      do
         @(negedge clock);
      while (pending_words.size() != 0 || req_tvalid || expected_results.size() != 0);
      repeat (drain_cycles) @(posedge clock);
      phase_count++;
   endtask

   function automatic logic [CFG_W-1:0] pick_threshold();
      int r;
      r = $urandom_range(0, 99);
      if (r < 65)
         return $urandom_range(0, 6);
      else if (r < 78)
         return $urandom_range(7, 24);
      else if (r < 86)
         return '1;
      else if (r < 92)
         return '0;
      else
         return $urandom();
   endfunction

   function automatic logic [CFG_W-1:0] pick_cooldown();
      int r;
      r = $urandom_range(0, 99);
      if (r < 88)
         return $urandom_range(0, 4);
      else if (r < 94)
         return '1;
      else
         return $urandom();
   endfunction

   task automatic configure_random();
      logic [CFG_W-1:0] mn;
      logic [CFG_W-1:0] mx;
      mn = pick_threshold();
      mx = pick_threshold();
      set_config(1'($urandom_range(0, 1)), mn, mx, pick_cooldown());
      if ($urandom_range(0, 3) == 0) begin
         // writes to indexes past the register file must leave everything as is
         write_reg(CSR_INDEX_W'($urandom_range(int'(REG_COOLDOWN) + 1, 255)), $urandom());
         end_writes();
      end
   endtask

   // Mostly press/release runs sized around the window, with takes and some noise.
   task automatic build_sequence(int count);
      int start;
      int lo;
      int hi;
      int cl;
      int r;
      start = words_queued;
      lo = (cfg_min > 12) ? 12 : int'(cfg_min);
      hi = (cfg_max > 12) ? 12 : int'(cfg_max);
      if (hi < lo)
         hi = lo;
      cl = (cfg_cool > 6) ? 6 : int'(cfg_cool);
      while (words_queued - start < count) begin
         r = $urandom_range(0, 99);
         if (r < 12) begin
            add_word(OP_TAKE, 1'($urandom_range(0, 1)));
         end else if (r < 22) begin
            add_word(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
         end else begin
            add_run(1'b1, $urandom_range((lo == 0) ? 0 : lo - 1, hi + 2));
            add_run(1'b0, $urandom_range(1, cl + 2));
            if ($urandom_range(0, 2) == 0)
               add_word(OP_TAKE, 1'($urandom_range(0, 1)));
         end
      end
   endtask

   initial begin
      int random_words;
      random_words = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Reset settings: press mode, zero minimum, so the first press latches at once.
      add_word(OP_SAMPLE, 1'b1);
      add_word(OP_TAKE, 1'b1);
      add_word(OP_TAKE, 1'b0);
      add_word(OP_SAMPLE, 1'b0);
      add_word(OP_SAMPLE, 1'b1);
      add_word(OP_TAKE, 1'b0);
      settle(4);

      // Release window [2,3] with cooldown: qualify, ride out the cooldown, overlong press.
      set_config(1'b1, 2, 3, 2);
      add_run(1'b1, 2);
      add_run(1'b0, 1);
      add_word(OP_TAKE, 1'b0);
      add_run(1'b1, 1);
      add_run(1'b0, 2);
      add_run(1'b1, 4);
      add_run(1'b0, 1);
      add_word(OP_TAKE, 1'b1);
      settle(4);

      // Inverted window: fault flag, press mode with zero minimum and no cooldown.
      set_config(1'b1, 5, 1, '1);
      write_reg(REG_COOLDOWN + 1'b1, '1);
      end_writes();
      add_run(1'b1, 1);
      add_word(OP_TAKE, 1'b0);
      add_run(1'b1, 1);
      add_word(OP_TAKE, 1'b1);
      settle(4);

      // Zero window in release mode: a release with no press at all qualifies.
      set_config(1'b1, 0, 0, 0);
      add_run(1'b0, 1);
      add_word(OP_TAKE, 1'b0);
      add_run(1'b1, 1);
      add_run(1'b0, 1);
      add_word(OP_TAKE, 1'b1);
      settle(4);

      // Extremes: unreachable minimum in press mode, then widest window in release mode.
      set_config(1'b0, '1, '1, '1);
      build_sequence(40);
      settle(4);
      set_config(1'b1, 0, '1, 0);
      build_sequence(40);
      settle(4);

      // Random settings, one phase each.
      while (random_words < RANDOM_WORDS) begin
         configure_random();
         build_sequence($urandom_range(60, 160));
         random_words = words_queued;
         settle(4);
      end

      settle(8);
      if (expected_results.size() != 0)
         report_failure($sformatf("%0d responses never arrived", expected_results.size()));

      $display("covered %0d words in %0d phases, %0d responses checked", words_sent,
               phase_count, results_checked);
      $display("events taken %0d, responses with fault flag %0d, mismatches %0d",
               events_seen, fault_results, error_count);
      if (error_count == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
hw/rtl/kpeq_pkg.sv
hw/rtl/kpeq_csr.sv
hw/rtl/kpeq_core.sv
hw/rtl/key_press_event_qualifier.sv
bench/key_press_event_qualifier_tb.sv
